// File: hdl/mfsgd_pkg.sv
package mfsgd_pkg;

  typedef enum logic [2:0] {
    OP_WRITE_LEFT  = 3'd0,
    OP_WRITE_RIGHT = 3'd1,
    OP_TRAIN       = 3'd2,
    OP_READ_LEFT   = 3'd3,
    OP_READ_RIGHT  = 3'd4
  } op_t;

  localparam logic CFG_REG_STRENGTH = 1'b0;
  localparam logic CFG_RANK_IN_USE  = 1'b1;

  localparam logic [24:0] REG_STRENGTH_RESET = 25'd16777;
  localparam logic [7:0]  RANK_IN_USE_RESET  = 8'd100;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_READ_DATA,
    ST_DOT_ADDR,
    ST_DOT_MUL,
    ST_DOT_ACC,
    ST_PRED,
    ST_ERR,
    ST_UPD_ADDR,
    ST_WAIT_L,
    ST_UPD_R,
    ST_WAIT_R,
    ST_WRITE_R,
    ST_DONE
  } state_t;

  // Request to the weight update unit: w - step * 2 * (g * other + lambda * w).
  typedef struct packed {
    logic               start;
    logic signed [31:0] w;
    logic signed [31:0] other;
    logic signed [32:0] g;
    logic [24:0]        step;
    logic [24:0]        lambda;
  } upd_req_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] new_w;
    logic               sat;
  } upd_rsp_t;

  // Clips to 32 bits; the top bit of the result is the clip flag.
  function automatic logic [32:0] clip32(input logic signed [71:0] x);
    logic [32:0] res;
    if (x > 72'sd2147483647) begin
      res = {1'b1, 32'h7fff_ffff};
    end else if (x < -72'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, x[31:0]};
    end
    return res;
  endfunction

endpackage

// File: hdl/mfsgd_if.sv
interface mfsgd_in_if;
  import mfsgd_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [11:0]        row_index;
  logic [11:0]        col_index;
  logic [6:0]         factor_index;
  logic signed [31:0] weight_value;
  logic signed [31:0] rating_value;
  logic [24:0]        learn_rate;

  modport source (output valid, operation, row_index, col_index, factor_index,
                  weight_value, rating_value, learn_rate, input ready);
  modport sink (input valid, operation, row_index, col_index, factor_index,
                weight_value, rating_value, learn_rate, output ready);
endinterface

interface mfsgd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic signed [31:0] prediction;
  logic signed [31:0] error_value;
  logic               saturated;

  modport source (output valid, read_value, prediction, error_value, saturated,
                  input ready);
  modport sink (input valid, read_value, prediction, error_value, saturated,
                output ready);
endinterface

// File: hdl/mfsgd_ram.sv
module mfsgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/mfsgd_upd.sv
module mfsgd_upd import mfsgd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  upd_req_t req,
  output upd_rsp_t rsp
);

  logic [3:0] v_r;

  logic signed [64:0] p1_r;
  logic signed [57:0] p2_r;
  logic signed [31:0] w1_r, w2_r, w3_r;
  logic [24:0]        step1_r, step2_r;
  logic signed [31:0] grad2_r;
  logic               sat2_r, sat3_r;
  logic signed [57:0] p3_r;
  logic signed [31:0] new_w_r;
  logic               sat4_r;

  logic signed [65:0] t_sum;
  logic signed [65:0] t_rnd;
  logic [32:0]        grad_clip;
  logic signed [57:0] d_rnd;
  logic signed [34:0] n_sum;
  logic [32:0]        n_clip;

  always_comb begin
    t_sum     = 66'(p1_r) + 66'(p2_r);
    t_rnd     = (t_sum + (66'sd1 <<< 22)) >>> 23;
    grad_clip = clip32(72'(t_rnd));
    d_rnd     = (p3_r + (58'sd1 <<< 23)) >>> 24;
    n_sum     = 35'(w3_r) - 35'(d_rnd);
    n_clip    = clip32(72'(n_sum));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], req.start};
    end
    p1_r    <= req.g * req.other;
    p2_r    <= $signed({1'b0, req.lambda}) * req.w;
    w1_r    <= req.w;
    step1_r <= req.step;
    grad2_r <= grad_clip[31:0];
    sat2_r  <= grad_clip[32];
    w2_r    <= w1_r;
    step2_r <= step1_r;
    p3_r    <= $signed({1'b0, step2_r}) * grad2_r;
    sat3_r  <= sat2_r;
    w3_r    <= w2_r;
    new_w_r <= n_clip[31:0];
    sat4_r  <= sat3_r | n_clip[32];
  end

  assign rsp.valid = v_r[3];
  assign rsp.new_w = new_w_r;
  assign rsp.sat   = sat4_r;

endmodule

// File: hdl/matrix_factorization_sgd_update.sv
// Matrix-factorization SGD update engine with L2 regularization.
// Items arrive on in_ch (valid/ready); an item transfers on a clock edge where
// both are high. Each item yields exactly one result on out_ch. Operations
// write or read one Q8.24 weight of the left (row) or right (column) factor
// memory, or run one train step on a row, column, rating and step size.
// One item is worked on at a time. A train step with R factors runs a dot
// product pass over the R factors and then an update pass, both paced by the
// single read port of each factor memory and the 4-stage weight update unit
// shared by both updates.
// The result sits in an output register; a new item is accepted while it
// waits, and the engine only holds at its final state if the receiver stalls
// with the output register still full.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// must only be issued while the block is idle.
// Reset (rst_n, synchronous, active low) restores the configuration defaults
// and clears the control state; the factor memories are not cleared and hold
// garbage until each weight is written.
module matrix_factorization_sgd_update import mfsgd_pkg::*; #(
  parameter int NUM_ROWS = 4096,
  parameter int NUM_COLS = 4096,
  parameter int MAX_RANK = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  mfsgd_in_if.sink    in_ch,
  mfsgd_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [24:0] cfg_data
);

  localparam int L_DEPTH = NUM_ROWS * MAX_RANK;
  localparam int R_DEPTH = NUM_COLS * MAX_RANK;
  localparam int LAW     = (L_DEPTH > 1) ? $clog2(L_DEPTH) : 1;
  localparam int RAW     = (R_DEPTH > 1) ? $clog2(R_DEPTH) : 1;
  localparam int KW      = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int RKW     = $clog2(MAX_RANK + 1);
  localparam int ACC_W   = 40 + RKW;

  // Configuration registers.
  logic [24:0] lambda_r;
  logic [7:0]  rank_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lambda_r   <= REG_STRENGTH_RESET;
      rank_cfg_r <= RANK_IN_USE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REG_STRENGTH: lambda_r   <= cfg_data;
        CFG_RANK_IN_USE:  rank_cfg_r <= cfg_data[7:0];
        default:          ;
      endcase
    end
  end

  state_t state_r, state_nxt;

  // Latched item and working registers.
  logic [2:0]         op_r;
  logic [LAW-1:0]     lbase_r;
  logic [RAW-1:0]     rbase_r;
  logic [KW-1:0]      fac_r;
  logic signed [31:0] wval_r;
  logic signed [31:0] rating_r;
  logic [24:0]        step_r;
  logic [RKW-1:0]     erank_r;
  logic [KW-1:0]      k_r;
  logic signed [63:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [31:0] pred_r, err_r, rd_r;
  logic signed [31:0] rw_r, newl_r, newr_r;
  logic               sat_r;

  logic               out_valid_r;
  logic signed [31:0] out_rd_r, out_pred_r, out_err_r;
  logic               out_sat_r;

  // Item decode at the input.
  logic           in_xfer;
  logic           row_ok, col_ok, fac_ok;
  logic [31:0]    lbase_full, rbase_full;
  logic [RKW-1:0] erank_nxt;

  assign in_xfer    = in_ch.valid && in_ch.ready;
  assign row_ok     = 32'(in_ch.row_index) < 32'(NUM_ROWS);
  assign col_ok     = 32'(in_ch.col_index) < 32'(NUM_COLS);
  assign fac_ok     = 32'(in_ch.factor_index) < 32'(MAX_RANK);
  assign lbase_full = 32'(in_ch.row_index) * 32'(MAX_RANK);
  assign rbase_full = 32'(in_ch.col_index) * 32'(MAX_RANK);
  assign erank_nxt  = (32'(rank_cfg_r) > 32'(MAX_RANK)) ? RKW'(MAX_RANK)
                                                        : RKW'(rank_cfg_r);

  // Memory ports.
  logic            l_we, r_we;
  logic [LAW-1:0]  l_addr_w, l_raddr;
  logic [RAW-1:0]  r_addr_w, r_raddr;
  logic [31:0]     l_wdata, r_wdata, l_rdata, r_rdata;
  logic [KW-1:0]   sel_k;
  logic            k_last;

  assign sel_k   = (state_r == ST_READ || state_r == ST_WRITE) ? fac_r : k_r;
  assign l_raddr = lbase_r + LAW'(sel_k);
  assign r_raddr = rbase_r + RAW'(sel_k);
  assign l_addr_w = l_raddr;
  assign r_addr_w = r_raddr;
  assign k_last  = (RKW'(k_r) + RKW'(1)) == erank_r;

  mfsgd_ram #(.WIDTH(32), .DEPTH(L_DEPTH)) u_left_mem (
    .clk(clk), .we(l_we), .waddr(l_addr_w), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  mfsgd_ram #(.WIDTH(32), .DEPTH(R_DEPTH)) u_right_mem (
    .clk(clk), .we(r_we), .waddr(r_addr_w), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  // Shared weight update unit.
  upd_req_t upd_req;
  upd_rsp_t upd_rsp;

  mfsgd_upd u_upd (.clk(clk), .rst_n(rst_n), .req(upd_req), .rsp(upd_rsp));

  // First cycle of ST_WAIT_L: read data is valid.
  logic upd_first_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_DONE;
          case (in_ch.operation)
            OP_WRITE_LEFT:  if (row_ok && fac_ok) state_nxt = ST_WRITE;
            OP_WRITE_RIGHT: if (col_ok && fac_ok) state_nxt = ST_WRITE;
            OP_READ_LEFT:   if (row_ok && fac_ok) state_nxt = ST_READ;
            OP_READ_RIGHT:  if (col_ok && fac_ok) state_nxt = ST_READ;
            OP_TRAIN: begin
              if (row_ok && col_ok) begin
                state_nxt = (erank_nxt == '0) ? ST_PRED : ST_DOT_ADDR;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_WRITE:     state_nxt = ST_DONE;
      ST_READ:      state_nxt = ST_READ_DATA;
      ST_READ_DATA: state_nxt = ST_DONE;
      ST_DOT_ADDR:  state_nxt = ST_DOT_MUL;
      ST_DOT_MUL:   state_nxt = ST_DOT_ACC;
      ST_DOT_ACC:   state_nxt = k_last ? ST_PRED : ST_DOT_ADDR;
      ST_PRED:      state_nxt = ST_ERR;
      ST_ERR:       state_nxt = (erank_r == '0) ? ST_DONE : ST_UPD_ADDR;
      ST_UPD_ADDR:  state_nxt = ST_WAIT_L;
      ST_WAIT_L:    if (upd_rsp.valid) state_nxt = ST_UPD_R;
      ST_UPD_R:     state_nxt = ST_WAIT_R;
      ST_WAIT_R:    if (upd_rsp.valid) state_nxt = ST_WRITE_R;
      ST_WRITE_R:   state_nxt = k_last ? ST_DONE : ST_UPD_ADDR;
      ST_DONE:      if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer. The left update starts in the cycle after the
  // read address was issued, when both weights are at the memory outputs.
  logic upd_start_l;

  always_comb begin
    in_ch.ready   = (state_r == ST_IDLE);
    l_we          = 1'b0;
    r_we          = 1'b0;
    l_wdata       = wval_r;
    r_wdata       = wval_r;
    upd_start_l   = 1'b0;
    upd_req.start = 1'b0;
    upd_req.w     = l_rdata;
    upd_req.other = r_rdata;
    upd_req.g     = -33'(err_r);
    upd_req.step  = step_r;
    upd_req.lambda = lambda_r;
    case (state_r)
      ST_WRITE: begin
        l_we = (op_r == OP_WRITE_LEFT);
        r_we = (op_r == OP_WRITE_RIGHT);
      end
      ST_UPD_R: begin
        l_we          = 1'b1;
        l_wdata       = newl_r;
        upd_req.start = 1'b1;
        upd_req.w     = rw_r;
        upd_req.other = newl_r;
      end
      ST_WRITE_R: begin
        r_we    = 1'b1;
        r_wdata = newr_r;
      end
      default: ;
    endcase
    if (state_r == ST_WAIT_L && upd_first_r) begin
      upd_start_l   = 1'b1;
      upd_req.start = 1'b1;
    end
  end

  // Arithmetic for the dot product and error.
  logic signed [63:0] prod_rnd;
  logic [32:0]        pred_clip, err_clip;
  logic signed [33:0] diff;

  always_comb begin
    prod_rnd  = (prod_r + 64'sd8388608) >>> 24;
    pred_clip = clip32(72'(acc_r));
    diff      = 34'(rating_r) - 34'(pred_r);
    err_clip  = clip32(72'(diff));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      upd_first_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      upd_first_r <= (state_r == ST_UPD_ADDR);
      if (state_r == ST_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= in_ch.operation;
      lbase_r  <= lbase_full[LAW-1:0];
      rbase_r  <= rbase_full[RAW-1:0];
      fac_r    <= KW'(in_ch.factor_index);
      wval_r   <= in_ch.weight_value;
      rating_r <= in_ch.rating_value;
      step_r   <= in_ch.learn_rate;
      erank_r  <= erank_nxt;
      k_r      <= '0;
      acc_r    <= '0;
      pred_r   <= '0;
      err_r    <= '0;
      rd_r     <= '0;
      sat_r    <= 1'b0;
    end
    case (state_r)
      ST_READ_DATA: rd_r <= (op_r == OP_READ_LEFT) ? l_rdata : r_rdata;
      ST_DOT_MUL:   prod_r <= $signed(l_rdata) * $signed(r_rdata);
      ST_DOT_ACC: begin
        acc_r <= acc_r + ACC_W'(prod_rnd);
        k_r   <= k_last ? '0 : k_r + KW'(1);
      end
      ST_PRED: begin
        pred_r <= pred_clip[31:0];
        sat_r  <= sat_r | pred_clip[32];
      end
      ST_ERR: begin
        err_r <= err_clip[31:0];
        sat_r <= sat_r | err_clip[32];
      end
      ST_WAIT_L: begin
        if (upd_start_l) begin
          rw_r <= r_rdata;
        end
        if (upd_rsp.valid) begin
          newl_r <= upd_rsp.new_w;
          sat_r  <= sat_r | upd_rsp.sat;
        end
      end
      ST_WAIT_R: begin
        if (upd_rsp.valid) begin
          newr_r <= upd_rsp.new_w;
          sat_r  <= sat_r | upd_rsp.sat;
        end
      end
      ST_WRITE_R: k_r <= k_last ? '0 : k_r + KW'(1);
      default: ;
    endcase
    if (state_r == ST_DONE && (!out_valid_r || out_ch.ready)) begin
      out_rd_r   <= rd_r;
      out_pred_r <= pred_r;
      out_err_r  <= err_r;
      out_sat_r  <= sat_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = out_rd_r;
  assign out_ch.prediction  = out_pred_r;
  assign out_ch.error_value = out_err_r;
  assign out_ch.saturated   = out_sat_r;

  // The two memories are never written in the same cycle.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(l_we && r_we)) else $error("both factor memories written at once");

  // The update unit only answers while the sequencer waits for it.
  a_upd_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    upd_rsp.valid |-> (state_r == ST_WAIT_L || state_r == ST_WAIT_R))
    else $error("update result arrived outside a wait state");

  // The factor counter stays inside the rank in use during the update pass.
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD_ADDR) |-> (RKW'(k_r) < erank_r))
    else $error("factor counter beyond rank");

  // An accepted item always leaves the idle state.
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != ST_IDLE)) else $error("accepted item ignored");

  // The right weight read for the update is kept for the right update.
  a_lw_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT_R) |-> $stable(rw_r)) else $error("right weight lost");

endmodule

// File: bench/mfsgd_checker.sv
module mfsgd_checker import mfsgd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mfsgd_in_if         in_ch,
  mfsgd_out_if        out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [24:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          train_count,
  output int          sat_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] read_value;
    logic signed [31:0] prediction;
    logic signed [31:0] error_value;
    logic               saturated;
  } sgd_result_t;

  sgd_result_t expected_results[$];

  // Shadow copies of both factor memories; entries never written read as zero.
  logic signed [31:0] left_shadow[int];
  logic signed [31:0] right_shadow[int];
  logic [24:0] lambda_q;
  logic [7:0]  rank_q;

  function automatic longint round_q(longint y, int s);
    return (y + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clip_q(longint x, inout bit flag);
    if (x > 64'sd2147483647) begin
      flag = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (x < -64'sd2147483648) begin
      flag = 1'b1;
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] shadow_get(bit right, int key);
    if (right) return right_shadow.exists(key) ? right_shadow[key] : 32'sd0;
    return left_shadow.exists(key) ? left_shadow[key] : 32'sd0;
  endfunction

  // Gradient step on one weight: w - step * 2 * (g * other + lambda * w).
  function automatic logic signed [31:0] descend(logic signed [31:0] w,
      logic signed [31:0] other, longint g, longint step, inout bit flag);
    longint t;
    logic signed [31:0] grad;
    longint delta;
    t = g * longint'(other) + longint'({1'b0, lambda_q}) * longint'(w);
    grad = clip_q(round_q(t, 23), flag);
    delta = round_q(step * longint'(grad), 24);
    return clip_q(longint'(w) - delta, flag);
  endfunction

  task automatic predict_result();
    sgd_result_t res;
    int lbase;
    int rbase;
    int rank;
    longint acc;
    longint g;
    longint step;
    bit sat;
    logic signed [31:0] lw;
    logic signed [31:0] rw;
    res = '{32'sd0, 32'sd0, 32'sd0, 1'b0};
    sat = 1'b0;
    lbase = int'(in_ch.row_index) * 128;
    rbase = int'(in_ch.col_index) * 128;
    case (in_ch.operation)
      OP_WRITE_LEFT: left_shadow[lbase + in_ch.factor_index] = in_ch.weight_value;
      OP_WRITE_RIGHT: right_shadow[rbase + in_ch.factor_index] = in_ch.weight_value;
      OP_READ_LEFT: res.read_value = shadow_get(1'b0, lbase + in_ch.factor_index);
      OP_READ_RIGHT: res.read_value = shadow_get(1'b1, rbase + in_ch.factor_index);
      OP_TRAIN: begin
        train_count++;
        rank = (rank_q > 8'd128) ? 128 : int'(rank_q);
        acc = 0;
        for (int k = 0; k < rank; k++) begin
          acc += round_q(longint'(shadow_get(1'b0, lbase + k)) *
                         longint'(shadow_get(1'b1, rbase + k)), 24);
        end
        res.prediction = clip_q(acc, sat);
        res.error_value = clip_q(longint'(in_ch.rating_value) -
                                 longint'(res.prediction), sat);
        g = -longint'(res.error_value);
        step = longint'({1'b0, in_ch.learn_rate});
        for (int k = 0; k < rank; k++) begin
          lw = descend(shadow_get(1'b0, lbase + k), shadow_get(1'b1, rbase + k),
                       g, step, sat);
          left_shadow[lbase + k] = lw;
          rw = descend(shadow_get(1'b1, rbase + k), lw, g, step, sat);
          right_shadow[rbase + k] = rw;
        end
        res.saturated = sat;
      end
      default: ;
    endcase
    if (res.saturated) sat_count++;
    expected_results.push_back(res);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    train_count = 0;
    sat_count = 0;
  end

  always @(posedge clk) begin
    sgd_result_t want;
    if (!rst_n) begin
      lambda_q <= REG_STRENGTH_RESET;
      rank_q <= RANK_IN_USE_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_REG_STRENGTH) lambda_q <= cfg_data;
        else rank_q <= cfg_data[7:0];
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t result transfer with nothing outstanding", $realtime);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.read_value !== want.read_value)
            report("read_value", out_ch.read_value, want.read_value);
          if (out_ch.prediction !== want.prediction)
            report("prediction", out_ch.prediction, want.prediction);
          if (out_ch.error_value !== want.error_value)
            report("error_value", out_ch.error_value, want.error_value);
          if (out_ch.saturated !== want.saturated)
            report("saturated", out_ch.saturated, want.saturated);
        end
      end
      if (in_ch.valid && in_ch.ready) predict_result();
      pending = expected_results.size();
    end
  end

endmodule

// File: bench/matrix_factorization_sgd_update_tb.sv
module matrix_factorization_sgd_update_tb;
  import mfsgd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // A train step at full rank makes no transfer at all while it runs, so the
  // watchdog limit sits well above its length.
  localparam int IDLE_LIMIT = 40000;
  localparam int PHASE_ITEMS = 30;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [24:0] cfg_data;
  int          fail_count;
  int          pending;
  int          train_count;
  int          sat_count;
  int          idle_cycles;
  int          stall_left;
  int          read_count;
  int          setting_count;
  bit          quiet;

  mfsgd_in_if  in_ch ();
  mfsgd_out_if out_ch ();

  matrix_factorization_sgd_update dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mfsgd_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .train_count(train_count), .sat_count(sat_count)
  );

  // Train steps only ever touch this row and column, and all of their 128
  // factors are written before the first train step, so no train step reads
  // a weight that was never written. Between them they hit both index
  // extremes.
  logic [11:0] pool_row = 12'd4095;
  logic [11:0] pool_col = 12'd0;

  // Keys of written entries, so that reads only land on written weights.
  bit left_written[int];
  bit right_written[int];
  int left_keys[$];
  int right_keys[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly no gap, sometimes a short one, rarely a long one; none at all
  // while the quiet flag is set.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic signed [31:0] pick_weight();
    if ($urandom_range(9) < 8) return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
    return $urandom;
  endfunction

  // The receiver stalls with the same distribution as the sender idles.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
      stall_left = pick_gap();
    end
  end

  // The watchdog restarts on every transfer on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  // The valid line is lowered only for a gap, and never within the same step
  // in which it is raised again.
  task automatic send_item(logic [2:0] op, logic [11:0] row, logic [11:0] col,
                           logic [6:0] fac, logic signed [31:0] wval,
                           logic signed [31:0] rating, logic [24:0] step);
    int gap;
    int key;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.operation = op;
    in_ch.row_index = row;
    in_ch.col_index = col;
    in_ch.factor_index = fac;
    in_ch.weight_value = wval;
    in_ch.rating_value = rating;
    in_ch.learn_rate = step;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_WRITE_LEFT) begin
      key = int'(row) * 128 + fac;
      if (!left_written.exists(key)) left_keys.push_back(key);
      left_written[key] = 1'b1;
    end else if (op == OP_WRITE_RIGHT) begin
      key = int'(col) * 128 + fac;
      if (!right_written.exists(key)) right_keys.push_back(key);
      right_written[key] = 1'b1;
    end else if (op == OP_READ_LEFT || op == OP_READ_RIGHT) begin
      read_count++;
    end
    @(negedge clk);
  endtask

  // Configuration is written only once every result is back; each item
  // yields a result, so the short extra wait just lets the engine settle.
  task automatic set_reg(logic idx, logic [24:0] value);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    setting_count++;
  endtask

  // Writes every factor of the pool row and column with mostly moderate values.
  task automatic load_pool();
    for (int k = 0; k < 128; k++) begin
      send_item(OP_WRITE_LEFT, pool_row, 12'($urandom), 7'(k), pick_weight(),
                $urandom, 25'($urandom));
      send_item(OP_WRITE_RIGHT, 12'($urandom), pool_col, 7'(k), pick_weight(),
                $urandom, 25'($urandom));
    end
  endtask

  task automatic send_train(logic signed [31:0] rating, logic [24:0] step);
    send_item(OP_TRAIN, pool_row, pool_col, 7'($urandom), $urandom, rating, step);
  endtask

  // One random item. Train steps use the well-formed pool with random
  // content; writes land anywhere, reads only on written entries, and a few
  // items carry the unused operation codes.
  task automatic send_random();
    int r;
    int key;
    logic signed [31:0] rating;
    logic [24:0] step;
    r = $urandom_range(99);
    if (r < 35) begin
      rating = ($urandom_range(9) < 8) ?
               $signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000 : $urandom;
      step = ($urandom_range(9) < 8) ? 25'($urandom_range(25'h8_0000)) : 25'($urandom);
      send_train(rating, step);
    end else if (r < 60) begin
      if ($urandom_range(1))
        send_item(OP_WRITE_LEFT, ($urandom_range(1) ? pool_row : 12'($urandom)),
                  12'($urandom), 7'($urandom), pick_weight(), $urandom, 25'($urandom));
      else
        send_item(OP_WRITE_RIGHT, 12'($urandom), ($urandom_range(1) ? pool_col :
                  12'($urandom)), 7'($urandom), pick_weight(), $urandom, 25'($urandom));
    end else if (r < 94) begin
      if ($urandom_range(1)) begin
        key = left_keys[$urandom_range(left_keys.size() - 1)];
        send_item(OP_READ_LEFT, 12'(key / 128), 12'($urandom), 7'(key % 128), $urandom,
                  $urandom, 25'($urandom));
      end else begin
        key = right_keys[$urandom_range(right_keys.size() - 1)];
        send_item(OP_READ_RIGHT, 12'($urandom), 12'(key / 128), 7'(key % 128), $urandom,
                  $urandom, 25'($urandom));
      end
    end else begin
      send_item(3'($urandom_range(7, 5)), 12'($urandom), 12'($urandom), 7'($urandom),
                $urandom, $urandom, 25'($urandom));
    end
  endtask

  initial begin
    logic [24:0] lam_list[8];
    logic [7:0]  rank_list[8];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_REG_STRENGTH;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_WRITE_LEFT;
    in_ch.row_index = '0;
    in_ch.col_index = '0;
    in_ch.factor_index = '0;
    in_ch.weight_value = '0;
    in_ch.rating_value = '0;
    in_ch.learn_rate = '0;
    stall_left = 0;
    read_count = 0;
    setting_count = 0;
    quiet = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, first with the reset configuration.
    load_pool();
    send_item(OP_WRITE_LEFT, 12'd5, 12'd0, 7'd0, 32'sh7fff_ffff, 32'sd0, 25'd0);
    send_item(OP_WRITE_LEFT, 12'd5, 12'd0, 7'd127, 32'sh8000_0000, 32'sd0, 25'd0);
    send_item(OP_WRITE_RIGHT, 12'd0, 12'd9, 7'd0, 32'sh8000_0000, 32'sd0, 25'd0);
    send_item(OP_READ_LEFT, 12'd5, 12'd0, 7'd0, 32'sd0, 32'sd0, 25'd0);
    send_item(OP_READ_LEFT, 12'd5, 12'd0, 7'd127, 32'sd0, 32'sd0, 25'd0);
    send_item(OP_READ_RIGHT, 12'd0, 12'd9, 7'd0, 32'sd0, 32'sd0, 25'd0);
    send_item(OP_READ_LEFT, 12'd4095, 12'd0, 7'd127, 32'sd0, 32'sd0, 25'd0);
    send_item(OP_READ_RIGHT, 12'd0, 12'd0, 7'd127, 32'sd0, 32'sd0, 25'd0);
    // Unused operation codes must leave the memories alone and return zeros.
    for (int c = 5; c < 8; c++)
      send_item(3'(c), 12'($urandom), 12'($urandom), 7'($urandom), $urandom, $urandom,
                25'($urandom));
    send_train(32'sh7fff_ffff, 25'd0);
    send_train(32'sh8000_0000, 25'h100_0000);
    send_train(32'sh0100_0000, 25'h1ff_ffff);
    send_train(32'sh0080_0000, 25'h1_0000);
    // Rank zero uses no factors at all.
    set_reg(CFG_RANK_IN_USE, 25'd0);
    send_train(32'sh0123_4567, 25'h4_0000);
    // A rank above MAX_RANK is limited to the full 128 factors.
    set_reg(CFG_RANK_IN_USE, 25'd200);
    send_train(32'sh0100_0000, 25'h1000);
    set_reg(CFG_REG_STRENGTH, 25'h100_0000);
    send_train(-32'sh0100_0000, 25'h1000);
    // Lambda and step above one are used exactly as given.
    set_reg(CFG_REG_STRENGTH, 25'h1ff_ffff);
    send_train(32'sh0040_0000, 25'h1ff_ffff);

    // Random phases across several settings, the extremes among them.
    // Most phases use a small rank so that train steps stay short.
    lam_list = '{25'd16777, 25'd0, 25'h100_0000, 25'h1ff_ffff, 25'd0, 25'd0, 25'd0, 25'd0};
    rank_list = '{8'd100, 8'd128, 8'd1, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
    for (int p = 4; p < 8; p++) begin
      lam_list[p] = 25'($urandom_range(25'h4_0000));
      rank_list[p] = 8'($urandom_range(8, 1));
    end
    for (int p = 0; p < 8; p++) begin
      set_reg(CFG_REG_STRENGTH, lam_list[p]);
      set_reg(CFG_RANK_IN_USE, {17'd0, rank_list[p]});
      quiet = (p == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random();
    end
    quiet = 1'b0;
    in_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    $display("Ran %0d train steps (%0d with saturation) and %0d reads under %0d settings.",
             train_count, sat_count, read_count, setting_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
